[hw/rtl/etb_pkg.sv]
// Shared types, codes and constants for the elimination tree builder.
// Used by every file under hw/rtl but etb_ram; depends on nothing.
package etb_pkg;

  // Default store depths, handed to the top level as parameter defaults
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF  = 1024;

  // Fixed field widths of the channels and registers
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_ENTRY = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNSYM      = 2'd0,
    MODE_SYM_UPPER  = 2'd1,
    MODE_SYM_LOWER  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_MODE  = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_ROW_COUNT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [MODE_W-1:0] matrix_mode;
    logic [CNT_W-1:0]  column_count;
    logic [CNT_W-1:0]  row_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ROW,
    ST_WALK,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;         // capture the item and issue the first reads
    logic clr_en;       // clear the sweep entry of every store deep enough for it
    logic row_we;       // record the column as the row's last column
    logic anc_rd_prev;  // start the climb at the row's previous column
    logic anc_we;       // point the current node's ancestor at the target
    logic par_we;       // set the current node's parent to the target
    logic anc_rd_up;    // step to the next ancestor
    logic out_load;     // load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;          // command of the item on the input channel
    logic sym_go;       // symmetric-upper entry that adds an edge
    logic uns_go;       // unsymmetric entry inside the matrix
    logic clr_last;     // last entry of the clearing sweep
    logic prev_lt;      // previous column of the row lies below the target
    logic hit;          // ancestor already equals the target
    logic up_none;      // ancestor chain ends here
  } dp_sts_t;

endpackage

[hw/rtl/etb_in_if.sv]
// Input channel of the elimination tree builder: valid, ready and one item.
// Depends on etb_pkg for the field widths.
interface etb_in_if;
  logic                      valid;
  logic                      ready;
  logic [etb_pkg::CMD_W-1:0] command;
  logic [etb_pkg::IDX_W-1:0] row_index;
  logic [etb_pkg::IDX_W-1:0] col_index;
  logic [etb_pkg::IDX_W-1:0] query_node;

  modport source (output valid, command, row_index, col_index, query_node, input ready);
  modport sink   (input valid, command, row_index, col_index, query_node, output ready);
endinterface

[hw/rtl/etb_out_if.sv]
// Result channel of the elimination tree builder: valid, ready and one item.
// Depends on etb_pkg for the field widths.
interface etb_out_if;
  logic                      valid;
  logic                      ready;
  logic [etb_pkg::IDX_W-1:0] parent_value;
  logic                      has_parent;
  logic                      status;

  modport source (output valid, parent_value, has_parent, status, input ready);
  modport sink   (input valid, parent_value, has_parent, status, output ready);
endinterface

[hw/rtl/etb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module etb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/etb_datapath.sv]
// Datapath of the elimination tree builder: item registers, the three stores,
// clearing counter and result register. Depends on etb_pkg and etb_ram.
module etb_datapath #(
  parameter int unsigned MAX_NODES = etb_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_ROWS  = etb_pkg::MAX_ROWS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  etb_pkg::cfg_t             cfg_i,
  input  etb_pkg::dp_cmd_t          cmd_i,
  output etb_pkg::dp_sts_t          sts_o,
  input  logic [etb_pkg::CMD_W-1:0] command_i,
  input  logic [etb_pkg::IDX_W-1:0] row_index_i,
  input  logic [etb_pkg::IDX_W-1:0] col_index_i,
  input  logic [etb_pkg::IDX_W-1:0] query_node_i,
  output logic [etb_pkg::IDX_W-1:0] parent_value_o,
  output logic                      has_parent_o,
  output logic                      status_o
);

  localparam int unsigned AW    = $clog2(MAX_NODES);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned EW    = AW + 1;
  localparam int unsigned CLR_N = (MAX_NODES > MAX_ROWS) ? MAX_NODES : MAX_ROWS;
  localparam int unsigned CLW   = $clog2(CLR_N);
  // Top bit marks an empty entry
  localparam logic [EW-1:0] NONE = {1'b1, {AW{1'b0}}};

  logic          row_ok, col_ok, query_ok;
  logic          mode_uns, mode_sym;
  logic [AW-1:0] to_q, node_q;
  logic [RW-1:0] row_q;
  etb_pkg::cmd_e cmd_q;
  logic          query_ok_q, unsup_q;
  logic [CLW-1:0] clr_q;
  logic          clr_last, clr_node, clr_row;

  logic          anc_we, anc_re, par_we, lcol_we;
  logic [AW-1:0] anc_waddr, anc_raddr, par_waddr;
  logic [EW-1:0] anc_wdata, par_wdata, lcol_wdata;
  logic [EW-1:0] anc_rdata, par_rdata, lcol_rdata;
  logic [RW-1:0] lcol_waddr;

  logic [etb_pkg::IDX_W-1:0] parent_q;
  logic                      has_q, status_q, has_d;

  // Range and mode checks on the item at the input
  assign row_ok   = ({1'b0, row_index_i} < cfg_i.row_count) &&
                    (32'(row_index_i) < MAX_ROWS);
  assign col_ok   = ({1'b0, col_index_i} < cfg_i.column_count) &&
                    (32'(col_index_i) < MAX_NODES);
  assign query_ok = ({1'b0, query_node_i} < cfg_i.column_count) &&
                    (32'(query_node_i) < MAX_NODES);
  assign mode_uns = (cfg_i.matrix_mode == etb_pkg::MODE_UNSYM);
  assign mode_sym = (cfg_i.matrix_mode == etb_pkg::MODE_SYM_UPPER);

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      to_q       <= AW'(col_index_i);
      row_q      <= RW'(row_index_i);
      node_q     <= AW'(row_index_i);
      cmd_q      <= etb_pkg::cmd_e'(command_i);
      query_ok_q <= query_ok;
      unsup_q    <= !(mode_uns || mode_sym);
    end else if (cmd_i.anc_rd_prev) begin
      node_q <= lcol_rdata[AW-1:0];
    end else if (cmd_i.anc_rd_up) begin
      node_q <= anc_rdata[AW-1:0];
    end
  end

  // Clearing sweep counter; rests at zero between sweeps
  assign clr_last = (32'(clr_q) == CLR_N - 1);
  assign clr_node = cmd_i.clr_en && (32'(clr_q) < MAX_NODES);
  assign clr_row  = cmd_i.clr_en && (32'(clr_q) < MAX_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_last ? '0 : clr_q + 1'b1;
    end
  end

  // Ancestor store
  assign anc_we    = clr_node || cmd_i.anc_we;
  assign anc_waddr = cmd_i.clr_en ? AW'(clr_q) : node_q;
  assign anc_wdata = cmd_i.clr_en ? NONE : {1'b0, to_q};
  assign anc_re    = cmd_i.take || cmd_i.anc_rd_prev || cmd_i.anc_rd_up;

  always_comb begin
    priority if (cmd_i.take) begin
      anc_raddr = AW'(row_index_i);
    end else if (cmd_i.anc_rd_prev) begin
      anc_raddr = lcol_rdata[AW-1:0];
    end else begin
      anc_raddr = anc_rdata[AW-1:0];
    end
  end

  etb_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_anc_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .re_i    (anc_re),
    .raddr_i (anc_raddr),
    .rdata_o (anc_rdata)
  );

  // Parent store: read only when an item is taken, so the data holds until the result
  assign par_we    = clr_node || cmd_i.par_we;
  assign par_waddr = cmd_i.clr_en ? AW'(clr_q) : node_q;
  assign par_wdata = cmd_i.clr_en ? NONE : {1'b0, to_q};

  etb_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .re_i    (cmd_i.take),
    .raddr_i (AW'(query_node_i)),
    .rdata_o (par_rdata)
  );

  // Last column seen per row
  assign lcol_we    = clr_row || cmd_i.row_we;
  assign lcol_waddr = cmd_i.clr_en ? RW'(clr_q) : row_q;
  assign lcol_wdata = cmd_i.clr_en ? NONE : {1'b0, to_q};

  etb_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS)) u_lcol_ram (
    .clk_i   (clk_i),
    .we_i    (lcol_we),
    .waddr_i (lcol_waddr),
    .wdata_i (lcol_wdata),
    .re_i    (cmd_i.take),
    .raddr_i (RW'(row_index_i)),
    .rdata_o (lcol_rdata)
  );

  // Status towards the controller
  always_comb begin
    sts_o.cmd      = etb_pkg::cmd_e'(command_i);
    sts_o.sym_go   = mode_sym && row_ok && col_ok && (row_index_i < col_index_i);
    sts_o.uns_go   = mode_uns && row_ok && col_ok;
    sts_o.clr_last = clr_last;
    sts_o.prev_lt  = !lcol_rdata[AW] && (lcol_rdata[AW-1:0] < to_q);
    sts_o.hit      = (anc_rdata == {1'b0, to_q});
    sts_o.up_none  = anc_rdata[AW];
  end

  // Result register
  assign has_d = (cmd_q == etb_pkg::CMD_READ) && query_ok_q && !par_rdata[AW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      has_q    <= has_d;
      parent_q <= has_d ? etb_pkg::IDX_W'(par_rdata[AW-1:0]) : '0;
      status_q <= unsup_q;
    end
  end

  assign parent_value_o = parent_q;
  assign has_parent_o   = has_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  // A climb never moves to the node it stands on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.anc_rd_up |-> (anc_rdata[AW-1:0] != node_q))
    else $error("ancestor chain steps onto itself");

  // The sweep counter rests at zero outside a clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clr_en |-> (clr_q == '0))
    else $error("clear counter not at rest");
`endif

endmodule

[hw/rtl/etb_ctrl.sv]
// Controller of the elimination tree builder: sequences clearing, row lookup,
// the ancestor climb and the result handshake. Depends on etb_pkg.
module etb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  etb_pkg::dp_sts_t sts_i,
  output etb_pkg::dp_cmd_t cmd_o
);

  etb_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etb_pkg::ST_INIT: begin
        if (sts_i.clr_last) begin
          state_d = etb_pkg::ST_IDLE;
        end
      end
      etb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.cmd)
            etb_pkg::CMD_START: state_d = etb_pkg::ST_CLEAR;
            etb_pkg::CMD_ENTRY: begin
              priority if (sts_i.sym_go) begin
                state_d = etb_pkg::ST_WALK;
              end else if (sts_i.uns_go) begin
                state_d = etb_pkg::ST_ROW;
              end else begin
                state_d = etb_pkg::ST_RESP;
              end
            end
            default: state_d = etb_pkg::ST_RESP;
          endcase
        end
      end
      etb_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = etb_pkg::ST_RESP;
        end
      end
      etb_pkg::ST_ROW: begin
        state_d = sts_i.prev_lt ? etb_pkg::ST_WALK : etb_pkg::ST_RESP;
      end
      etb_pkg::ST_WALK: begin
        if (sts_i.hit || sts_i.up_none) begin
          state_d = etb_pkg::ST_RESP;
        end
      end
      etb_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = etb_pkg::ST_IDLE;
        end
      end
      default: state_d = etb_pkg::ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      etb_pkg::ST_INIT, etb_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      etb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      etb_pkg::ST_ROW: begin
        cmd_o.row_we      = 1'b1;
        cmd_o.anc_rd_prev = sts_i.prev_lt;
      end
      etb_pkg::ST_WALK: begin
        if (!sts_i.hit) begin
          cmd_o.anc_we    = 1'b1;
          cmd_o.par_we    = sts_i.up_none;
          cmd_o.anc_rd_up = !sts_i.up_none;
        end
      end
      etb_pkg::ST_RESP: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etb_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // One item in flight: a taken item closes the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");
`endif

endmodule

[hw/rtl/elimination_tree_builder_unit.sv]
// Sequence: a read or non-edge item goes from acceptance straight to the result; a
// symmetric entry first climbs its ancestor chain, an unsymmetric entry first looks up
// its row's last column and climbs only if that column lies below the new one.
// One item at a time: the next item can be taken in the cycle after the result is loaded.
// Start: a clearing sweep over max(MAX_NODES, MAX_ROWS) entries, one entry per cycle.
// Reset: the same sweep runs first; no item is taken until it ends; state and config reset.
// Depends on etb_pkg, etb_in_if, etb_out_if, etb_ram, etb_datapath and etb_ctrl.
module elimination_tree_builder_unit #(
  parameter int unsigned MAX_NODES = etb_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_ROWS  = etb_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  etb_in_if.sink                         in_if,
  etb_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [etb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [etb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  etb_pkg::cfg_t    cfg_q;
  etb_pkg::dp_cmd_t dp_cmd;
  etb_pkg::dp_sts_t dp_sts;

  // Configuration registers, read by the datapath straight from here. Writes must arrive
  // only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matrix_mode  <= etb_pkg::MODE_UNSYM;
      cfg_q.column_count <= etb_pkg::COUNT_RESET;
      cfg_q.row_count    <= etb_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (etb_pkg::cfg_reg_e'(cfg_idx_i))
        etb_pkg::REG_MATRIX_MODE:  cfg_q.matrix_mode  <= cfg_data_i[etb_pkg::MODE_W-1:0];
        etb_pkg::REG_COLUMN_COUNT: cfg_q.column_count <= cfg_data_i;
        etb_pkg::REG_ROW_COUNT:    cfg_q.row_count    <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Controller: clearing sweep, row lookup, ancestor climb with path
  // compression, one step per cycle, and the result handshake.
  etb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Datapath: parent, ancestor and last-column stores, each in its own RAM,
  // plus the item and result registers.
  etb_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_ROWS  (MAX_ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .command_i      (in_if.command),
    .row_index_i    (in_if.row_index),
    .col_index_i    (in_if.col_index),
    .query_node_i   (in_if.query_node),
    .parent_value_o (out_if.parent_value),
    .has_parent_o   (out_if.has_parent),
    .status_o       (out_if.status)
  );

endmodule

[tb/tb_elimination_tree_builder_unit.sv]
`timescale 1ns / 100ps
// Self-checking bench for elimination_tree_builder_unit: drives start, entry, read and no-op
// items, predicts every parent reply and compares it. Needs etb_pkg and both channel interfaces.
module tb_elimination_tree_builder_unit;

  localparam int unsigned NODES      = etb_pkg::MAX_NODES_DEF;
  localparam int unsigned ROWS       = etb_pkg::MAX_ROWS_DEF;
  localparam int unsigned CMD_W      = etb_pkg::CMD_W;
  localparam int unsigned MODE_W     = etb_pkg::MODE_W;
  localparam int unsigned IDX_W      = etb_pkg::IDX_W;
  localparam int unsigned CNT_W      = etb_pkg::CNT_W;
  localparam int unsigned CFG_DATA_W = etb_pkg::CFG_DATA_W;
  localparam logic [CNT_W-1:0] NONE_MARK = CNT_W'(etb_pkg::MAX_NODES_DEF);
  // command and mode codes that the package leaves unnamed
  localparam logic [CMD_W-1:0]  CMD_NOP   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    logic [IDX_W-1:0] parent_value;
    logic             has_parent;
    logic             status;
  } reply_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  etb_pkg::cfg_reg_e     cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  etb_in_if  in_ch ();
  etb_out_if out_ch ();

  elimination_tree_builder_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock: 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Tree predictor: own copy of the three stores and the registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  parent_tab   [NODES];
  logic [CNT_W-1:0]  ancestor_tab [NODES];
  logic [CNT_W-1:0]  row_last_col [ROWS];
  logic [MODE_W-1:0] cur_mode;
  logic [CNT_W-1:0]  cur_cols;
  logic [CNT_W-1:0]  cur_rows;

  reply_t      pending_replies [$];
  int unsigned mismatch_cnt;
  int unsigned items_sent;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_left;

  function automatic void clear_tree();
    for (int i = 0; i < NODES; i++) begin
      parent_tab[i]   = NONE_MARK;
      ancestor_tab[i] = NONE_MARK;
    end
    for (int i = 0; i < ROWS; i++) row_last_col[i] = NONE_MARK;
  endfunction

  // Counts above the store depth behave as the depth
  function automatic int unsigned cols_eff();
    return (cur_cols > NODES) ? NODES : cur_cols;
  endfunction

  function automatic int unsigned rows_eff();
    return (cur_rows > ROWS) ? ROWS : cur_rows;
  endfunction

  // Climb from 'from' towards the root, pointing every ancestor on the way at 'to';
  // the node where the chain ends gets 'to' as its parent.
  function automatic void link_to_root(logic [CNT_W-1:0] from, logic [CNT_W-1:0] to);
    logic [CNT_W-1:0] node;
    logic [CNT_W-1:0] up;
    node = from;
    for (int s = 0; s <= NODES; s++) begin
      if (node >= NONE_MARK) return;
      up = ancestor_tab[node[IDX_W-1:0]];
      if (up == to) return;
      ancestor_tab[node[IDX_W-1:0]] = to;
      if (up >= NONE_MARK) begin
        parent_tab[node[IDX_W-1:0]] = to;
        return;
      end
      node = up;
    end
  endfunction

  function automatic reply_t predict_reply(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                           logic [IDX_W-1:0] col, logic [IDX_W-1:0] query);
    reply_t           rep;
    logic [CNT_W-1:0] prev;
    logic [CNT_W-1:0] par;
    rep = '0;
    rep.status = (cur_mode >= etb_pkg::MODE_SYM_LOWER);
    case (cmd)
      etb_pkg::CMD_START: clear_tree();
      etb_pkg::CMD_ENTRY: begin
        if (!rep.status && row < rows_eff() && col < cols_eff()) begin
          if (cur_mode == etb_pkg::MODE_SYM_UPPER) begin
            if (row < col) link_to_root({1'b0, row}, {1'b0, col});
          end else begin
            // tree of A'A: join the row's previous column to this one
            prev = row_last_col[row];
            if (prev < {1'b0, col}) link_to_root(prev, {1'b0, col});
            row_last_col[row] = {1'b0, col};
          end
        end
      end
      etb_pkg::CMD_READ: begin
        if (query < cols_eff()) begin
          par = parent_tab[query];
          if (par < NONE_MARK) begin
            rep.parent_value = par[IDX_W-1:0];
            rep.has_parent   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checker: each accepted reply against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("%0t: unexpected reply parent=%0d has=%b status=%b", $realtime,
                   out_ch.parent_value, out_ch.has_parent, out_ch.status);
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.parent_value !== want.parent_value || out_ch.has_parent !== want.has_parent ||
            out_ch.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("%0t: reply mismatch exp parent=%0d has=%b status=%b, got %0d %b %b",
                     $realtime, want.parent_value, want.has_parent, want.status,
                     out_ch.parent_value, out_ch.has_parent, out_ch.status);
        end
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (recv_hold_left != 0) begin
      out_ch.ready   <= 1'b0;
      recv_hold_left <= recv_hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one item from a falling edge; predict its reply once it is taken.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] query);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.command    = cmd;
    in_ch.row_index  = row;
    in_ch.col_index  = col;
    in_ch.query_node = query;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pending_replies.push_back(predict_reply(cmd, row, col, query));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic entry(input int unsigned row, input int unsigned col);
    send_item(etb_pkg::CMD_ENTRY, IDX_W'(row), IDX_W'(col),
              IDX_W'($urandom_range(NODES - 1)));
  endtask

  task automatic read_parent(input int unsigned node);
    send_item(etb_pkg::CMD_READ, IDX_W'($urandom_range(ROWS - 1)),
              IDX_W'($urandom_range(NODES - 1)), IDX_W'(node));
  endtask

  task automatic start_matrix();
    send_item(etb_pkg::CMD_START, IDX_W'($urandom_range(ROWS - 1)),
              IDX_W'($urandom_range(NODES - 1)), IDX_W'($urandom_range(NODES - 1)));
  endtask

  // Every item yields one reply, so the block is idle once all replies are back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input etb_pkg::cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      etb_pkg::REG_MATRIX_MODE:  cur_mode = val[MODE_W-1:0];
      etb_pkg::REG_COLUMN_COUNT: cur_cols = val;
      etb_pkg::REG_ROW_COUNT:    cur_rows = val;
      default: ;
    endcase
  endtask

  // Wait for idle, then write all three registers
  task automatic set_matrix(input logic [MODE_W-1:0] mode, input int unsigned cols,
                            input int unsigned rows);
    drain();
    write_reg(etb_pkg::REG_MATRIX_MODE, CFG_DATA_W'(mode));
    write_reg(etb_pkg::REG_COLUMN_COUNT, CFG_DATA_W'(cols));
    write_reg(etb_pkg::REG_ROW_COUNT, CFG_DATA_W'(rows));
  endtask

  // One well-formed matrix: start, column-major entries with a little noise and
  // interleaved reads, then parent reads of every column, or of random ones if wide.
  task automatic run_matrix(input int unsigned entry_n);
    int unsigned ncol;
    int unsigned nrow;
    int unsigned lim;
    int unsigned col;
    int unsigned stride;
    int unsigned pick;
    ncol   = cols_eff();
    nrow   = rows_eff();
    lim    = (nrow < ncol) ? nrow : ncol;
    col    = 0;
    stride = 2 * ncol / entry_n + 1;
    start_matrix();
    for (int k = 0; k < entry_n; k++) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_item(CMD_NOP, IDX_W'($urandom_range(ROWS - 1)),
                  IDX_W'($urandom_range(NODES - 1)), IDX_W'($urandom_range(NODES - 1)));
      end else if (pick < 6) begin
        // any row and column: out of range, backward or repeated
        entry($urandom_range(ROWS - 1), $urandom_range(NODES - 1));
      end else if (pick < 16) begin
        read_parent($urandom_range(ncol - 1));
      end else begin
        if ($urandom_range(1) == 1) col = col + $urandom_range(1, stride);
        if (col > ncol - 1) col = ncol - 1;
        // upper mode only links rows above the diagonal, so favour those
        if (cur_mode == etb_pkg::MODE_SYM_UPPER) entry($urandom_range(lim - 1), col);
        else entry($urandom_range(nrow - 1), col);
      end
    end
    if (ncol <= 64) begin
      for (int n = 0; n < ncol; n++) read_parent(n);
    end else begin
      repeat (32) read_parent($urandom_range(ncol - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: unsymmetric mode over the full 1024 x 1024 matrix
  task automatic test_reset_defaults();
    read_parent(NODES - 1);
    send_item(CMD_NOP, '1, '1, '1);
    entry(ROWS - 1, 0);
    entry(ROWS - 1, NODES - 1);      // joins node 0 to the last column
    read_parent(0);
  endtask

  task automatic test_unsymmetric();
    set_matrix(etb_pkg::MODE_UNSYM, 4, 4);
    start_matrix();
    entry(0, 0);
    entry(0, 2);
    entry(1, 1);
    entry(1, 2);
    entry(4, 3);                     // row outside the matrix: drop
    entry(0, 1);                     // column behind the row's last one: no edge
    entry(1, 4);                     // column outside the matrix: drop
    read_parent(0);
    read_parent(1);
  endtask

  task automatic test_symmetric_upper();
    set_matrix(etb_pkg::MODE_SYM_UPPER, 4, 4);
    start_matrix();
    entry(0, 3);
    entry(3, 1);                     // below the diagonal: no edge
    entry(2, 2);                     // diagonal: no edge
    entry(1, 3);
    read_parent(1);
  endtask

  task automatic test_modes_and_counts();
    set_matrix(etb_pkg::MODE_SYM_LOWER, 4, 4);
    entry(0, 1);                     // lower mode ignores entries
    read_parent(0);
    set_matrix(MODE_RSVD, 4, 1);
    start_matrix();
    set_matrix(etb_pkg::MODE_UNSYM, 0, 0);    // no valid index at all
    entry(0, 0);
    read_parent(0);
    set_matrix(etb_pkg::MODE_SYM_UPPER, 2047, 2047);
    entry(0, NODES - 1);
    read_parent(0);
  endtask

  // Stop taking replies for a long stretch while items keep coming
  task automatic test_backpressure();
    set_matrix(etb_pkg::MODE_UNSYM, 16, 16);
    @(posedge clk_i);
    recv_hold_left = 400;
    @(negedge clk_i);
    run_matrix(30);
  endtask

  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input int unsigned quota);
    int unsigned stop;
    int unsigned k;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop = items_sent + quota;
    k    = 0;
    while (items_sent < stop) begin
      case (k % 4)
        0: set_matrix(etb_pkg::MODE_UNSYM, $urandom_range(2, 32), $urandom_range(2, 48));
        1: set_matrix(etb_pkg::MODE_SYM_UPPER, $urandom_range(2, 32), $urandom_range(2, 32));
        2: set_matrix((k % 8 == 2) ? etb_pkg::MODE_UNSYM : etb_pkg::MODE_SYM_UPPER,
                      NODES, ROWS);
        default: set_matrix((k % 8 == 3) ? etb_pkg::MODE_SYM_LOWER : MODE_RSVD,
                            $urandom_range(2, 32), $urandom_range(2, 32));
      endcase
      if (k % 4 == 3) begin
        run_matrix(10);
      end else if (k % 4 == 2) begin
        run_matrix($urandom_range(80, 160));
      end else begin
        run_matrix($urandom_range(20, 60));
        run_matrix($urandom_range(20, 60));
      end
      k++;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = etb_pkg::CMD_START;
    in_ch.row_index  = '0;
    in_ch.col_index  = '0;
    in_ch.query_node = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = etb_pkg::REG_MATRIX_MODE;
    cfg_data         = '0;
    mismatch_cnt     = 0;
    items_sent       = 0;
    cycle_cnt        = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_left   = 0;
    cur_mode         = etb_pkg::MODE_UNSYM;
    cur_cols         = etb_pkg::COUNT_RESET;
    cur_rows         = etb_pkg::COUNT_RESET;
    clear_tree();

    // Hold reset, then release it on a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_unsymmetric();
    test_symmetric_upper();
    test_modes_and_counts();
    test_backpressure();
    test_random_phase(29, 56, 400);
    test_random_phase(56, 29, 400);
    test_random_phase(0, 0, 400);

    // Let the last replies arrive, then a short tail for anything stray
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
